/* rtl/mfhd_pkg.sv */
// Shared types and constants for the MQTT fixed-header deframer.
// No dependencies; imported by every module of the block.
package mfhd_pkg;

   localparam int MAX_LENGTH_BYTES_DEF = 4;
   localparam int LEN_W                = 28;
   localparam logic [7:0] CONT_BIT_MASK = 8'h80;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_ERROR   = 2'd3
   } mfhd_phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_LENGTH  = 2'd1,
      KIND_PAYLOAD = 2'd2,
      KIND_DROPPED = 2'd3
   } mfhd_kind_type;

   typedef struct packed {
      logic [7:0]       byte_value;
      mfhd_kind_type    byte_kind;
      logic [3:0]       packet_type;
      logic [3:0]       header_flags;
      logic [LEN_W-1:0] rem_length;
      logic             length_valid;
      logic             packet_end;
      logic             malformed;
   } mfhd_result_type;

endpackage

/* rtl/mfhd_decode.sv */
// Deframer state and per-byte decode: phase, header, length accumulation,
// payload countdown. Depends on mfhd_pkg.
module mfhd_decode
   import mfhd_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic [7:0]      data_byte,
   output mfhd_result_type result
);

   mfhd_phase_type   phase_ff, phase_in;
   logic [7:0]       header_ff, header_in;
   logic [LEN_W-1:0] acc_ff, acc_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [LEN_W-1:0] left_ff, left_in;

   logic [LEN_W-1:0] shifted;
   logic [LEN_W-1:0] acc_or;
   logic [LEN_W-1:0] left_dec;
   logic [2:0]       cnt_next;
   logic             last_allowed;

   // 7-bit group placed by its position in the length field
   always_comb begin
      unique case (cnt_ff)
         2'd0: shifted = {21'b0, data_byte[6:0]};
         2'd1: shifted = {14'b0, data_byte[6:0], 7'b0};
         2'd2: shifted = {7'b0, data_byte[6:0], 14'b0};
         2'd3: shifted = {data_byte[6:0], 21'b0};
         default: shifted = '0;
      endcase
   end

   assign acc_or       = acc_ff | shifted;
   assign left_dec     = left_ff - LEN_W'(1);
   assign cnt_next     = {1'b0, cnt_ff} + 3'd1;
   assign last_allowed = (cnt_next >= 3'(MAX_LENGTH_BYTES));

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      left_in   = left_ff;

      result.byte_value   = data_byte;
      result.byte_kind    = KIND_DROPPED;
      result.rem_length   = '0;
      result.length_valid = 1'b0;
      result.packet_end   = 1'b0;

      unique case (phase_ff)
         PH_HEADER: begin
            header_in = data_byte;
            acc_in    = '0;
            cnt_in    = '0;
            left_in   = '0;
            phase_in  = PH_LENGTH;
            result.byte_kind = KIND_HEADER;
         end
         PH_LENGTH: begin
            result.byte_kind = KIND_LENGTH;
            acc_in = acc_or;
            if ((data_byte & CONT_BIT_MASK) != 8'h00) begin
               if (last_allowed) begin
                  phase_in = PH_ERROR;
               end else begin
                  cnt_in = cnt_next[1:0];
               end
            end else begin
               result.rem_length   = acc_or;
               result.length_valid = 1'b1;
               if (acc_or == '0) begin
                  result.packet_end = 1'b1;
                  phase_in = PH_HEADER;
               end else begin
                  left_in  = acc_or;
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            result.byte_kind    = KIND_PAYLOAD;
            result.rem_length   = acc_ff;
            result.length_valid = 1'b1;
            left_in = left_dec;
            if (left_dec == '0) begin
               result.packet_end = 1'b1;
               phase_in = PH_HEADER;
            end
         end
         PH_ERROR: begin
            result.byte_kind = KIND_DROPPED;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      // header nibbles reflect the header as of after this byte
      result.packet_type  = header_in[7:4];
      result.header_flags = header_in[3:0];
      result.malformed    = (phase_in == PH_ERROR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         header_ff <= '0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         left_ff   <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         left_ff   <= left_in;
      end
   end

   // error is terminal until reset
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |=> phase_ff == PH_ERROR)
      else $error("deframer left error phase");

   // payload phase always has at least one byte still owed
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != '0)
      else $error("payload phase with nothing left");

   // length byte count never reaches the configured limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LENGTH |-> ({1'b0, cnt_ff} < 3'(MAX_LENGTH_BYTES)))
      else $error("length byte count beyond limit");

endmodule

/* rtl/mfhd_out_reg.sv */
// Result register of the deframer: holds one decoded item until taken.
// Depends on mfhd_pkg.
module mfhd_out_reg
   import mfhd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  mfhd_result_type in_result,
   output logic            out_valid,
   output mfhd_result_type out_result
);

   logic            vld_ff, vld_in;
   mfhd_result_type res_ff;

   assign vld_in = advance ? in_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         res_ff <= in_result;
      end
   end

   assign out_valid  = vld_ff;
   assign out_result = res_ff;

   // a dropped byte is always flagged malformed
   a_drop_malformed: assert property (@(posedge clock) disable iff (reset)
      vld_ff && res_ff.byte_kind == KIND_DROPPED |-> res_ff.malformed)
      else $error("dropped item without malformed");

   // packet end only comes with a decoded length and no error
   a_end_valid: assert property (@(posedge clock) disable iff (reset)
      vld_ff && res_ff.packet_end |-> res_ff.length_valid && !res_ff.malformed)
      else $error("packet end without valid length");

endmodule

/* rtl/mqtt_fixed_header_deframer.sv */
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   data_byte
// rsp_      out        rsp_valid/rsp_stall   byte_value, kind, header, length, flags
//
// One result per byte; one byte per cycle sustained while rsp_stall is low; each
// byte passes the input register, then decode into the result register.
// Synchronous active-high reset returns the framer to expecting a header.
// A stalled result holds the pipe; req_stall rises only when both the input
// and result registers are full and rsp_stall is high.
// Depends on mfhd_pkg, mfhd_decode, mfhd_out_reg.
module mqtt_fixed_header_deframer
   import mfhd_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_byte_value,
   output logic [1:0]       rsp_byte_kind,
   output logic [3:0]       rsp_packet_type,
   output logic [3:0]       rsp_header_flags,
   output logic [LEN_W-1:0] rsp_rem_length,
   output logic             rsp_length_valid,
   output logic             rsp_packet_end,
   output logic             rsp_malformed
);

   logic            in_vld_ff, in_vld_in;
   logic [7:0]      in_data_ff;
   logic            advance;
   logic            in_load;
   logic            fire;
   logic            out_vld;
   mfhd_result_type dec_result;
   mfhd_result_type out_result;

   assign advance = !out_vld || !rsp_stall;
   assign in_load = !in_vld_ff || advance;
   assign fire    = in_vld_ff && advance;

   assign req_stall = !in_load;
   assign in_vld_in = in_load ? req_valid : in_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_data_ff <= req_data_byte;
      end
   end

   mfhd_decode #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .data_byte(in_data_ff),
      .result   (dec_result)
   );

   mfhd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (in_vld_ff),
      .in_result (dec_result),
      .out_valid (out_vld),
      .out_result(out_result)
   );

   assign rsp_valid        = out_vld;
   assign rsp_byte_value   = out_result.byte_value;
   assign rsp_byte_kind    = out_result.byte_kind;
   assign rsp_packet_type  = out_result.packet_type;
   assign rsp_header_flags = out_result.header_flags;
   assign rsp_rem_length   = out_result.rem_length;
   assign rsp_length_valid = out_result.length_valid;
   assign rsp_packet_end   = out_result.packet_end;
   assign rsp_malformed    = out_result.malformed;

endmodule

/* tb/mfhd_deframe_checker.sv */
// Scoreboard for the MQTT fixed-header deframer: predicts each result from the
// accepted input bytes and compares it with the result channel field by field.
// Depends on mfhd_pkg.
module mfhd_deframe_checker
   import mfhd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [7:0]       rsp_byte_value,
   input  logic [1:0]       rsp_byte_kind,
   input  logic [3:0]       rsp_packet_type,
   input  logic [3:0]       rsp_header_flags,
   input  logic [LEN_W-1:0] rsp_rem_length,
   input  logic             rsp_length_valid,
   input  logic             rsp_packet_end,
   input  logic             rsp_malformed,
   output int               error_count,
   output int               results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // framer state as seen from the stream
   mfhd_phase_type   frame_phase;
   logic [7:0]       header_byte;
   logic [LEN_W-1:0] length_acc;
   logic [1:0]       length_bytes_seen;
   logic [LEN_W-1:0] payload_left;
   logic             malformed_seen;

   mfhd_result_type expected_results[$];
   int              fail_total = 0;

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      fail_total++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   function automatic mfhd_result_type deframe_byte(input logic [7:0] data);
      mfhd_result_type r;
      r            = '0;
      r.byte_value = data;
      r.byte_kind  = KIND_DROPPED;
      if (malformed_seen || frame_phase == PH_ERROR) begin
         // error is terminal until reset
         malformed_seen = 1'b1;
         frame_phase    = PH_ERROR;
      end else if (frame_phase == PH_HEADER) begin
         header_byte       = data;
         length_acc        = '0;
         length_bytes_seen = '0;
         payload_left      = '0;
         frame_phase       = PH_LENGTH;
         r.byte_kind       = KIND_HEADER;
      end else if (frame_phase == PH_LENGTH) begin
         r.byte_kind = KIND_LENGTH;
         length_acc  = length_acc | (LEN_W'(data[6:0]) << (7 * length_bytes_seen));
         if ((data & CONT_BIT_MASK) != 0) begin
            if (length_bytes_seen + 1 >= MAX_LENGTH_BYTES_DEF) begin
               malformed_seen = 1'b1;
               frame_phase    = PH_ERROR;
            end else begin
               length_bytes_seen = length_bytes_seen + 2'd1;
            end
         end else begin
            r.rem_length   = length_acc;
            r.length_valid = 1'b1;
            if (length_acc == 0) begin
               r.packet_end = 1'b1;
               frame_phase  = PH_HEADER;
            end else begin
               payload_left = length_acc;
               frame_phase  = PH_PAYLOAD;
            end
         end
      end else begin
         r.byte_kind    = KIND_PAYLOAD;
         r.rem_length   = length_acc;
         r.length_valid = 1'b1;
         payload_left   = payload_left - 1'b1;
         if (payload_left == 0) begin
            r.packet_end = 1'b1;
            frame_phase  = PH_HEADER;
         end
      end
      r.packet_type  = header_byte[7:4];
      r.header_flags = header_byte[3:0];
      r.malformed    = malformed_seen;
      return r;
   endfunction

   always @(posedge clock) begin : scoreboard
      mfhd_result_type want;
      mfhd_result_type predicted;
      if (reset) begin
         frame_phase       = PH_HEADER;
         header_byte       = '0;
         length_acc        = '0;
         length_bytes_seen = '0;
         payload_left      = '0;
         malformed_seen    = 1'b0;
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predicted        = deframe_byte(req_data_byte);
            expected_results = {expected_results, predicted};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_error($sformatf("result with nothing outstanding, byte_value 0x%0h",
                                      rsp_byte_value));
            end else begin
               want = expected_results.pop_front();
               check_field("byte_value", rsp_byte_value, want.byte_value);
               check_field("byte_kind", rsp_byte_kind, want.byte_kind);
               check_field("packet_type", rsp_packet_type, want.packet_type);
               check_field("header_flags", rsp_header_flags, want.header_flags);
               check_field("rem_length", rsp_rem_length, want.rem_length);
               check_field("length_valid", rsp_length_valid, want.length_valid);
               check_field("packet_end", rsp_packet_end, want.packet_end);
               check_field("malformed", rsp_malformed, want.malformed);
            end
         end
      end
      results_pending <= expected_results.size();
      error_count     <= fail_total;
   end

endmodule

/* tb/mqtt_fixed_header_deframer_tb.sv */
// Top of the deframer testbench: clock, reset, byte stream stimulus, receiver
// stalls, watchdog and verdict. Checking lives in mfhd_deframe_checker.
// Depends on mfhd_pkg, mqtt_fixed_header_deframer and mfhd_deframe_checker.
module mqtt_fixed_header_deframer_tb;
   import mfhd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_ITEMS    = 480;
   localparam int RANDOM_TARGET  = 1430;
   localparam int HOLD_AT_ITEM   = 300;
   localparam int HOLD_CYCLES    = 48;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int OPENING_ITEMS  = 20;

   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             req_valid     = 1'b0;
   logic             req_stall;
   logic [7:0]       req_data_byte = '0;
   logic             rsp_valid;
   logic             rsp_stall     = 1'b0;
   logic [7:0]       rsp_byte_value;
   logic [1:0]       rsp_byte_kind;
   logic [3:0]       rsp_packet_type;
   logic [3:0]       rsp_header_flags;
   logic [LEN_W-1:0] rsp_rem_length;
   logic             rsp_length_valid;
   logic             rsp_packet_end;
   logic             rsp_malformed;

   int error_count;
   int results_pending;
   int items_sent   = 0;
   int tx_idle_pct  = 12;
   int rx_idle_pct  = 54;
   int quiet_cycles = 0;
   bit hold_done    = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   mqtt_fixed_header_deframer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_byte_kind    (rsp_byte_kind),
      .rsp_packet_type  (rsp_packet_type),
      .rsp_header_flags (rsp_header_flags),
      .rsp_rem_length   (rsp_rem_length),
      .rsp_length_valid (rsp_length_valid),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_malformed    (rsp_malformed)
   );

   mfhd_deframe_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_byte_kind    (rsp_byte_kind),
      .rsp_packet_type  (rsp_packet_type),
      .rsp_header_flags (rsp_header_flags),
      .rsp_rem_length   (rsp_rem_length),
      .rsp_length_valid (rsp_length_valid),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_malformed    (rsp_malformed),
      .error_count      (error_count),
      .results_pending  (results_pending)
   );

   // offer one byte, with random idle cycles ahead of it, and wait until taken
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      tx_idle_pct = (items_sent < PHASE_ITEMS) ? 12 :
                    (items_sent < 2 * PHASE_ITEMS) ? 54 : 0;
      rx_idle_pct = (items_sent < PHASE_ITEMS) ? 54 :
                    (items_sent < 2 * PHASE_ITEMS) ? 12 : 0;
   endtask

   // header, length spread over length_bytes groups (padded with zero groups),
   // then random payload
   task automatic send_packet(input logic [7:0] header, input int unsigned payload_len,
                              input int length_bytes);
      int i;
      send_byte(header);
      for (i = 0; i < length_bytes; i++)
         send_byte({1'(i < length_bytes - 1), 7'(payload_len >> (7 * i))});
      for (i = 0; i < payload_len; i++)
         send_byte(8'($urandom_range(255)));
   endtask

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            // long hold-off so the pipe fills and the input stalls
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [7:0]  opening [OPENING_ITEMS];
      int unsigned payload_len;
      int          need;
      int          length_bytes;
      int          pick;
      int          i;

      opening = '{8'h00, 8'h00,                                // zero length
                  8'hFF, 8'h01, 8'hFF,                         // all-ones header
                  8'h30, 8'h82, 8'h80, 8'h80, 8'h00, 8'h00, 8'hFF, // four length bytes
                  8'hA5, 8'h80, 8'h00,                         // padded zero length
                  8'h5A, 8'h03, 8'hAA, 8'h55, 8'h80};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < OPENING_ITEMS; i++)
         send_byte(opening[i]);

      while (items_sent < RANDOM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 10)
            payload_len = 0;
         else if (pick < 75)
            payload_len = $urandom_range(12, 1);
         else if (pick < 95)
            payload_len = $urandom_range(127, 13);
         else
            payload_len = $urandom_range(400, 128);
         need = (payload_len < 128) ? 1 : 2;
         length_bytes = ($urandom_range(99) < 60) ? need :
                        $urandom_range(MAX_LENGTH_BYTES_DEF, need);
         send_packet(8'($urandom_range(255)), payload_len, length_bytes);
      end

      // overlong length: the error is sticky, so it has to come last
      send_byte(8'($urandom_range(255)));
      for (i = 0; i < MAX_LENGTH_BYTES_DEF; i++)
         send_byte(CONT_BIT_MASK | 8'($urandom_range(127)));
      for (i = 0; i < 10; i++)
         send_byte(8'($urandom_range(255)));

      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* files.f */
rtl/mfhd_pkg.sv
rtl/mfhd_decode.sv
rtl/mfhd_out_reg.sv
rtl/mqtt_fixed_header_deframer.sv
tb/mfhd_deframe_checker.sv
tb/mqtt_fixed_header_deframer_tb.sv
